>>> rtl/kpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared constants and codes for the keyframe path interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

   localparam int MAX_KEYS_DEF = 16;
   localparam int FRAC_BITS    = 16;
   localparam int WORD_W       = 32;
   localparam int KEY_W        = 3 * WORD_W;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_POS    = 2'd1;
   localparam logic [1:0] ACT_VEL    = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOSEG   = 2'd2;

   localparam logic [FRAC_BITS:0] ONE_Q16 = {1'b1, {FRAC_BITS{1'b0}}};

endpackage
`default_nettype wire

>>> rtl/kpi_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/kpi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_div
// Restoring divider, one quotient bit per cycle. Expects num < den and
// returns floor(num * 2^FRAC_BITS / den).
// ----------------------------------------------------------------------------
module kpi_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] num,
   input  wire logic [32:0] den,
   output logic             done,
   output logic [15:0]      quot
);
   import kpi_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);

   logic              run_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [32:0]       rem_ff;
   logic [32:0]       den_ff;
   logic [33:0]       rem_sh;
   logic              ge;

   assign rem_sh = {rem_ff, 1'b0};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= ge ? 33'(rem_sh - {1'b0, den_ff}) : rem_sh[32:0];
         quot   <= {quot[14:0], ge};
      end
   end

endmodule
`default_nettype wire

>>> rtl/keyframe_path_interpolator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_path_interpolator_core
// Piecewise linear 2D keyframe track in Q16.16 with position/velocity query.
// ----------------------------------------------------------------------------
// One request at a time; busy is high while a request is in work and each
// result is shown for one cycle on rsp_valid, which the receiver cannot
// stall. An append, an unused action or a query on an empty track answers
// straight from idle. A query scans the stored keys from one RAM port, a
// fetch and a check state per key; on a hit on a segment it then runs a serial
// divide, a multiply and an add, at or after the last key it takes that
// key's point, and with no segment it answers with NOSEG status.
module keyframe_path_interpolator_core #(
   parameter int MAX_KEYS = kpi_pkg::MAX_KEYS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_point_x,
   input  wire logic [31:0] req_point_y,
   input  wire logic [31:0] req_time_in,
   output logic             rsp_valid,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [1:0]       rsp_status
);
   import kpi_pkg::*;

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_CHECK, S_DIV, S_MULT, S_SUM, S_FINAL
   } state_type;

   state_type      state_ff;
   logic [CW-1:0]  count_ff;
   logic [AW-1:0]  idx_ff;
   logic           vel_ff;
   logic [16:0]    t_ff;
   logic [31:0]    px_ff, py_ff;
   logic [31:0]    prev_t_ff, prev_x_ff, prev_y_ff;
   logic [31:0]    cur_x_ff, cur_y_ff;
   logic [31:0]    res_x_ff, res_y_ff;
   logic [49:0]    prod_x_ff, prod_y_ff;
   logic           div_start_ff;
   logic [32:0]    div_num_ff, div_den_ff;
   logic           div_done;
   logic [15:0]    div_quot;

   logic           accept;
   logic           ram_we;
   logic [KEY_W-1:0] rdata;
   logic [31:0]    cur_t, cur_x, cur_y;
   logic signed [32:0] t_s, cur_ts, prev_ts;
   logic           hit, last, after_last;
   logic signed [32:0] dx, dy, vx, vy;
   logic [16:0]    t_clamp;

   assign busy   = state_ff != S_IDLE;
   assign accept = start && !busy;
   assign ram_we = accept && req_action == ACT_APPEND && count_ff < CW'(MAX_KEYS);

   kpi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({req_time_in, req_point_x, req_point_y}),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   kpi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign {cur_t, cur_x, cur_y} = rdata;
   assign t_s        = $signed({16'b0, t_ff});
   assign cur_ts     = $signed({cur_t[31], cur_t});
   assign prev_ts    = $signed({prev_t_ff[31], prev_t_ff});
   assign hit        = idx_ff != '0 && t_s >= prev_ts && t_s < cur_ts;
   assign last       = CW'({1'b0, idx_ff}) + CW'(1) == count_ff;
   assign after_last = t_s >= cur_ts;

   assign dx = $signed({cur_x_ff[31], cur_x_ff}) - $signed({prev_x_ff[31], prev_x_ff});
   assign dy = $signed({cur_y_ff[31], cur_y_ff}) - $signed({prev_y_ff[31], prev_y_ff});
   assign vx = $signed({res_x_ff[31], res_x_ff}) - $signed({px_ff[31], px_ff});
   assign vy = $signed({res_y_ff[31], res_y_ff}) - $signed({py_ff[31], py_ff});

   always_comb begin
      if ($signed(req_time_in) < 0) begin
         t_clamp = '0;
      end else if ($signed(req_time_in) > $signed({15'b0, ONE_Q16})) begin
         t_clamp = ONE_Q16;
      end else begin
         t_clamp = req_time_in[16:0];
      end
   end

   function automatic logic [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         sat32 = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid    <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         rsp_valid    <= 1'b0;
         div_start_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  vel_ff     <= req_action == ACT_VEL;
                  t_ff       <= t_clamp;
                  px_ff      <= req_point_x;
                  py_ff      <= req_point_y;
                  idx_ff     <= '0;
                  rsp_out_x  <= '0;
                  rsp_out_y  <= '0;
                  rsp_status <= ST_OK;
                  if (req_action == ACT_APPEND) begin
                     rsp_valid <= 1'b1;
                     if (ram_we) begin
                        count_ff <= count_ff + CW'(1);
                     end else begin
                        rsp_status <= ST_FULL;
                     end
                  end else if (req_action == ACT_POS || req_action == ACT_VEL) begin
                     if (count_ff == '0) begin
                        rsp_valid  <= 1'b1;
                        rsp_status <= ST_NOSEG;
                     end else begin
                        state_ff <= S_FETCH;
                     end
                  end else begin
                     rsp_valid <= 1'b1;
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               cur_x_ff <= cur_x;
               cur_y_ff <= cur_y;
               if (hit) begin
                  div_num_ff   <= 33'(t_s - prev_ts);
                  div_den_ff   <= 33'(cur_ts - prev_ts);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end else begin
                  prev_t_ff <= cur_t;
                  prev_x_ff <= cur_x;
                  prev_y_ff <= cur_y;
                  if (last) begin
                     if (after_last) begin
                        res_x_ff <= cur_x;
                        res_y_ff <= cur_y;
                        state_ff <= S_FINAL;
                     end else begin
                        rsp_valid  <= 1'b1;
                        rsp_out_x  <= '0;
                        rsp_out_y  <= '0;
                        rsp_status <= ST_NOSEG;
                        state_ff   <= S_IDLE;
                     end
                  end else begin
                     idx_ff   <= idx_ff + AW'(1);
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_MULT;
               end
            end
            S_MULT: begin
               prod_x_ff <= 50'(dx * $signed({1'b0, div_quot}));
               prod_y_ff <= 50'(dy * $signed({1'b0, div_quot}));
               state_ff  <= S_SUM;
            end
            S_SUM: begin
               res_x_ff <= prev_x_ff + prod_x_ff[47:16];
               res_y_ff <= prev_y_ff + prod_y_ff[47:16];
               state_ff <= S_FINAL;
            end
            S_FINAL: begin
               rsp_valid  <= 1'b1;
               rsp_status <= ST_OK;
               rsp_out_x  <= vel_ff ? sat32(vx) : res_x_ff;
               rsp_out_y  <= vel_ff ? sat32(vy) : res_y_ff;
               state_ff   <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
